// ----- sv/shift_jis_glyph_layout_macros.svh -----
// assertion helpers shared by the layout modules
`ifndef SHIFT_JIS_GLYPH_LAYOUT_MACROS_SVH
`define SHIFT_JIS_GLYPH_LAYOUT_MACROS_SVH

// implication checked on every clock edge once out of reset
`define SJGL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequence is checked in the cycle after the antecedent
`define SJGL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sjgl_pkg.sv -----
`default_nettype none

package sjgl_pkg;

  // geometry
  localparam int CELL_WIDTH   = 6;
  localparam int CELL_HEIGHT  = 12;
  localparam int SCREEN_WIDTH = 480;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int GLYPH_W = 14;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 16;

  // port widths
  localparam int IN_TDATA_W  = 2 * BYTE_W;
  localparam int OUT_FIELD_W = GLYPH_W + COL_W + ROW_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_COLUMN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_ROW    = 1'd1;

  // right-edge limits
  localparam logic [COL_W-1:0] HALF_LIMIT = COL_W'(SCREEN_WIDTH - CELL_WIDTH);
  localparam logic [COL_W-1:0] PAIR_LIMIT = COL_W'(SCREEN_WIDTH - 2 * CELL_WIDTH);
  localparam logic [COL_W-1:0] HALF_STEP  = COL_W'(CELL_WIDTH);
  localparam logic [COL_W-1:0] PAIR_STEP  = COL_W'(2 * CELL_WIDTH);
  localparam logic [ROW_W-1:0] LINE_STEP  = ROW_W'(CELL_HEIGHT);

  // special bytes and glyphs
  localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'h0A;
  localparam logic [GLYPH_W-1:0] BLANK_GLYPH  = 14'd176;
  // 176 - 2 * 0x40, folded into the double-width formula
  localparam logic [GLYPH_W-1:0] PAIR_BASE    = 14'd48;
  localparam logic [GLYPH_W-1:0] ROW_STRIDE   = 14'd384;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one queued character: one cell, or two cells side by side
  typedef struct packed {
    logic               pair;
    logic [GLYPH_W-1:0] glyph;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } sjgl_job_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } sjgl_qstat_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] row;
  } sjgl_lead_row_t;

  function automatic logic is_lead(input logic [BYTE_W-1:0] c);
    return (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hEF);
  endfunction

  function automatic logic is_trail(input logic [BYTE_W-1:0] c);
    return (c >= 8'h40 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'hFC);
  endfunction

  function automatic logic [GLYPH_W-1:0] half_index(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    v = '0;
    if (c >= 8'h20 && c <= 8'h7E) v = c - 8'h20;
    else if (c >= 8'hA1 && c <= 8'hDF) v = c - 8'h40;
    else if (c >= 8'hF0 && c <= 8'hFA) v = c - 8'h50;
    return GLYPH_W'(v);
  endfunction

  // font row of a lead byte, by its low six bits; gaps have no row
  function automatic sjgl_lead_row_t lead_row(input logic [5:0] slot);
    sjgl_lead_row_t r;
    r.hit = 1'b1;
    r.row = '0;
    if (slot >= 6'd1 && slot <= 6'd4) r.row = slot - 6'd1;
    else if (slot >= 6'd7 && slot <= 6'd42) r.row = slot - 6'd3;
    else if (slot == 6'd45 || slot == 6'd46) r.row = slot - 6'd5;
    else r.hit = 1'b0;
    return r;
  endfunction

  function automatic logic [GLYPH_W-1:0] full_index(input logic [BYTE_W-1:0] lead,
                                                    input logic [BYTE_W-1:0] trail);
    sjgl_lead_row_t lr;
    logic [GLYPH_W-1:0] idx;
    lr  = lead_row(lead[5:0]);
    idx = PAIR_BASE + GLYPH_W'(lr.row) * ROW_STRIDE + GLYPH_W'({trail, 1'b0});
    return lr.hit ? idx : BLANK_GLYPH;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sjgl_front.sv -----
`default_nettype none
`include "shift_jis_glyph_layout_macros.svh"

module sjgl_front
  import sjgl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   accept,
  input  wire logic [BYTE_W-1:0]      text_byte,
  input  wire logic [BYTE_W-1:0]      lookahead_byte,
  input  wire logic                   end_of_string,
  output logic                        push,
  output sjgl_job_t                   job
);

  logic [COL_W-1:0]  start_col_r;
  logic [ROW_W-1:0]  start_row_r;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [BYTE_W-1:0] pend_r, pend_nxt;
  logic              halt_r, halt_nxt;
  logic              in_str_r, in_str_nxt;

  logic [COL_W-1:0]  eff_col;
  logic [ROW_W-1:0]  eff_row;
  logic [BYTE_W-1:0] eff_pend;
  logic              eff_halt;
  logic              emit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_col_r <= '0;
      start_row_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_COLUMN: start_col_r <= cfg_data[COL_W-1:0];
        REG_START_ROW:    start_row_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // first byte of a string starts from the registers
  assign eff_col  = in_str_r ? cur_col_r : start_col_r;
  assign eff_row  = in_str_r ? cur_row_r : start_row_r;
  assign eff_pend = in_str_r ? pend_r : '0;
  assign eff_halt = in_str_r ? halt_r : 1'b0;

  // classify the byte and advance the cursor
  always_comb begin
    cur_col_nxt = eff_col;
    cur_row_nxt = eff_row;
    pend_nxt    = eff_pend;
    halt_nxt    = eff_halt;
    emit        = 1'b0;
    job.pair    = 1'b0;
    job.glyph   = half_index(text_byte);
    job.col     = eff_col;
    job.row     = eff_row;
    if (!eff_halt) begin
      if (text_byte == NEWLINE_BYTE) begin
        cur_col_nxt = start_col_r;
        cur_row_nxt = eff_row + LINE_STEP;
        pend_nxt    = '0;
      end else if (eff_pend != '0) begin
        if (eff_col > PAIR_LIMIT) begin
          halt_nxt = 1'b1;
        end else begin
          emit        = 1'b1;
          job.pair    = 1'b1;
          job.glyph   = full_index(eff_pend, text_byte);
          cur_col_nxt = eff_col + PAIR_STEP;
        end
        pend_nxt = '0;
      end else if (is_lead(text_byte) && is_trail(lookahead_byte)) begin
        pend_nxt = text_byte;
      end else if (eff_col > HALF_LIMIT) begin
        halt_nxt = 1'b1;
      end else begin
        emit        = 1'b1;
        cur_col_nxt = eff_col + HALF_STEP;
      end
    end
    in_str_nxt = !end_of_string;
  end

  assign push = accept && emit;

  // cursor state, held between transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      pend_r    <= '0;
      halt_r    <= 1'b0;
      in_str_r  <= 1'b0;
    end else if (accept) begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      pend_r    <= pend_nxt;
      halt_r    <= halt_nxt;
      in_str_r  <= in_str_nxt;
    end
  end

  `SJGL_ASSERT_IMP(a_halt_silent, in_str_r && halt_r, !push, "halted string produced a cell")
  `SJGL_ASSERT_IMP(a_pair_has_lead, push && job.pair, eff_pend != '0, "pair without a lead byte")

endmodule

`default_nettype wire

// ----- sv/sjgl_queue.sv -----
`default_nettype none
`include "shift_jis_glyph_layout_macros.svh"

module sjgl_queue
  import sjgl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire sjgl_job_t wr_job,
  input  wire logic      pop,
  output sjgl_job_t      rd_job,
  output sjgl_qstat_t    stat
);

  sjgl_job_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_job;
  end

  `SJGL_ASSERT_IMP(a_count_bound, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
  `SJGL_ASSERT_NEXT(a_push_lands, push && !pop && !stat.full, !stat.empty, "pushed job lost")

endmodule

`default_nettype wire

// ----- sv/sjgl_back.sv -----
`default_nettype none
`include "shift_jis_glyph_layout_macros.svh"

module sjgl_back
  import sjgl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sjgl_job_t               rd_job,
  input  wire sjgl_qstat_t             stat,
  output logic                         pop,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,
  output logic                         out_tlast
);

  logic               out_valid_r, out_valid_nxt;
  logic [GLYPH_W-1:0] out_glyph_r, out_glyph_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic               out_last_r, out_last_nxt;
  logic               sec_valid_r, sec_valid_nxt;
  logic [GLYPH_W-1:0] sec_glyph_r, sec_glyph_nxt;
  logic [COL_W-1:0]   sec_col_r, sec_col_nxt;
  logic [ROW_W-1:0]   sec_row_r, sec_row_nxt;
  logic               load;

  assign load = !out_valid_r || out_tready;

  // pick the next cell: right half of a pair first, then the queue head
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_glyph_nxt = out_glyph_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_last_nxt  = out_last_r;
    sec_valid_nxt = sec_valid_r;
    sec_glyph_nxt = sec_glyph_r;
    sec_col_nxt   = sec_col_r;
    sec_row_nxt   = sec_row_r;
    pop           = 1'b0;
    if (load) begin
      if (sec_valid_r) begin
        out_valid_nxt = 1'b1;
        out_glyph_nxt = sec_glyph_r;
        out_col_nxt   = sec_col_r;
        out_row_nxt   = sec_row_r;
        out_last_nxt  = 1'b1;
        sec_valid_nxt = 1'b0;
      end else if (!stat.empty) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        out_glyph_nxt = rd_job.glyph;
        out_col_nxt   = rd_job.col;
        out_row_nxt   = rd_job.row;
        out_last_nxt  = !rd_job.pair;
        sec_valid_nxt = rd_job.pair;
        sec_glyph_nxt = rd_job.glyph + 1'b1;
        sec_col_nxt   = rd_job.col + HALF_STEP;
        sec_row_nxt   = rd_job.row;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  // cell payload
  always_ff @(posedge clk) begin
    out_glyph_r <= out_glyph_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_last_r  <= out_last_nxt;
    sec_glyph_r <= sec_glyph_nxt;
    sec_col_r   <= sec_col_nxt;
    sec_row_r   <= sec_row_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_row_r, out_col_r, out_glyph_r});

  `SJGL_ASSERT_IMP(a_sec_behind_out, sec_valid_r, out_valid_r, "right half without left half")
  `SJGL_ASSERT_IMP(a_left_not_last, out_valid_r && !out_last_r, sec_valid_r,
                   "left half shown with no right half held")

endmodule

`default_nettype wire

// ----- sv/shift_jis_glyph_layout.sv -----
// Shift-JIS glyph layout: takes one string byte per transfer (with the next
// byte as lookahead and tlast on the final byte) and returns one transfer per
// font cell, giving glyph index, pixel column and pixel row; tlast marks the
// last cell a byte produced. A half-width byte gives one cell, a double-width
// pair gives two cells on the trail byte, paired lead bytes and newlines give none.
// The front takes a byte every cycle while its two-entry job queue has room;
// the back drives one cell per cycle through a single output register while
// out_tready is high. A byte's first cell passes through the job queue and
// then the output register. The start column and row registers are loaded
// into the cursor on the first byte of each string; write them only between
// strings. cfg_ready is always high.
`default_nettype none

module shift_jis_glyph_layout
  import sjgl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input bytes
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // text_byte[7:0], lookahead_byte[15:8]
  input  wire logic                   in_tlast,   // end_of_string
  // output cells
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // glyph_index[13:0], cell_column[22:14],
                                                  // cell_row[38:23], zero pad[39]
  output logic                        out_tlast   // run_last
);

  logic        in_xfer;
  logic        push;
  logic        pop;
  sjgl_job_t   wr_job;
  sjgl_job_t   rd_job;
  sjgl_qstat_t stat;

  assign cfg_ready = 1'b1;
  assign in_tready = !stat.full;
  assign in_xfer   = in_tvalid && in_tready;

  sjgl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (in_xfer),
    .text_byte      (in_tdata[BYTE_W-1:0]),
    .lookahead_byte (in_tdata[2*BYTE_W-1:BYTE_W]),
    .end_of_string  (in_tlast),
    .push           (push),
    .job            (wr_job)
  );

  sjgl_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (stat)
  );

  sjgl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_job     (rd_job),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- bench/shift_jis_glyph_layout_tb.sv -----
`default_nettype none

module shift_jis_glyph_layout_tb;
  import sjgl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;

  // one expected font cell
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               last;
  } cell_t;

  // tracks the text cursor and holds the cells still owed by the block
  class glyph_scoreboard;
    logic [COL_W-1:0]  start_col = '0;
    logic [ROW_W-1:0]  start_row = '0;
    logic [COL_W-1:0]  cur_col = '0;
    logic [ROW_W-1:0]  cur_row = '0;
    logic [BYTE_W-1:0] lead = '0;
    bit                halted = 1'b0;
    bit                in_string = 1'b0;
    cell_t             owed_cells[$];
    int errors, bytes_seen, strings_seen, cells_checked;
    int pairs_seen, newlines_seen, edge_stops, row_wraps;

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_START_COLUMN) start_col = val[COL_W-1:0];
      else if (idx == REG_START_ROW) start_row = val[ROW_W-1:0];
    endfunction

    function void restart();
      cur_col = start_col;
      cur_row = start_row;
      lead = '0;
      halted = 1'b0;
      in_string = 1'b0;
    endfunction

    function void push_cell(logic [GLYPH_W-1:0] g, logic [COL_W-1:0] c,
                            logic [ROW_W-1:0] r, logic l);
      cell_t entry;
      entry.glyph = g;
      entry.col = c;
      entry.row = r;
      entry.last = l;
      owed_cells.push_back(entry);
    endfunction

    // advance the cursor for one accepted byte and queue the cells it draws
    function void note_byte(logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] nxt, logic last);
      int font_row;
      int idx;
      logic [GLYPH_W-1:0] g;
      bit ch_lead;
      bit nxt_trail;
      bytes_seen++;
      if (!in_string) begin
        restart();
        in_string = 1'b1;
      end
      ch_lead = (ch >= 8'h81 && ch <= 8'h9F) || (ch >= 8'hE0 && ch <= 8'hEF);
      nxt_trail = (nxt >= 8'h40 && nxt <= 8'h7E) || (nxt >= 8'h80 && nxt <= 8'hFC);
      if (!halted) begin
        if (ch == NEWLINE_BYTE) begin
          newlines_seen++;
          if (int'(cur_row) + CELL_HEIGHT > 65535) row_wraps++;
          cur_col = start_col;
          cur_row = cur_row + ROW_W'(CELL_HEIGHT);
          lead = '0;
        end else if (lead != '0) begin
          if (int'(cur_col) > SCREEN_WIDTH - 2 * CELL_WIDTH) begin
            halted = 1'b1;
            edge_stops++;
          end else begin
            // font row of the lead byte; gaps in the table draw a blank cell
            if (lead >= 8'h81 && lead <= 8'h84) font_row = lead - 8'h81;
            else if (lead >= 8'h87 && lead <= 8'h9F) font_row = lead - 8'h87 + 4;
            else if (lead >= 8'hE0 && lead <= 8'hEA) font_row = lead - 8'hE0 + 29;
            else if (lead == 8'hED || lead == 8'hEE) font_row = lead - 8'hED + 40;
            else font_row = -1;
            if (font_row < 0) idx = 176;
            else idx = 176 + font_row * 384 + (int'(ch) - 64) * 2;
            g = GLYPH_W'(idx);
            push_cell(g, cur_col, cur_row, 1'b0);
            push_cell(g + 14'd1, cur_col + COL_W'(CELL_WIDTH), cur_row, 1'b1);
            cur_col = cur_col + COL_W'(2 * CELL_WIDTH);
            pairs_seen++;
          end
          lead = '0;
        end else if (ch_lead && nxt_trail) begin
          lead = ch;
        end else if (int'(cur_col) > SCREEN_WIDTH - CELL_WIDTH) begin
          halted = 1'b1;
          edge_stops++;
        end else begin
          if (ch >= 8'h20 && ch <= 8'h7E) g = GLYPH_W'(ch - 8'h20);
          else if (ch >= 8'hA1 && ch <= 8'hDF) g = GLYPH_W'(ch - 8'h40);
          else if (ch >= 8'hF0 && ch <= 8'hFA) g = GLYPH_W'(ch - 8'h50);
          else g = '0;
          push_cell(g, cur_col, cur_row, 1'b1);
          cur_col = cur_col + COL_W'(CELL_WIDTH);
        end
      end
      if (last) begin
        restart();
        strings_seen++;
      end
    endfunction

    // compare one cell transfer with the oldest owed cell
    function void check_cell(logic [GLYPH_W-1:0] g, logic [COL_W-1:0] c,
                             logic [ROW_W-1:0] r, logic l);
      cell_t want;
      if (owed_cells.size() == 0) begin
        errors++;
        $display("%0t: unexpected cell, expected none, got glyph %0d col %0d row %0d last %0b",
                 $time, g, c, r, l);
      end else begin
        want = owed_cells.pop_front();
        cells_checked++;
        if (want.glyph !== g || want.col !== c || want.row !== r || want.last !== l) begin
          errors++;
          $display("%0t: cell mismatch, expected glyph %0d col %0d row %0d last %0b",
                   $time, want.glyph, want.col, want.row, want.last);
          $display("%0t:                got      glyph %0d col %0d row %0d last %0b",
                   $time, g, c, r, l);
        end
      end
    endfunction

    function int outstanding();
      return owed_cells.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_START_COLUMN;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // text_byte[7:0], lookahead_byte[15:8]
  logic                   in_tlast = 1'b0; // end_of_string
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // glyph_index[13:0], cell_column[22:14],
                                           // cell_row[38:23], zero pad[39]
  logic                   out_tlast;       // run_last

  glyph_scoreboard sb;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int phase_bytes;
  logic [BYTE_W-1:0] str_bytes[$];

  shift_jis_glyph_layout uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // note input transfers and check output transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_byte(in_tdata[7:0], in_tdata[15:8], in_tlast);
      if (out_tvalid && out_tready)
        sb.check_cell(out_tdata[13:0], out_tdata[22:14], out_tdata[38:23], out_tlast);
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task send_byte(input logic [BYTE_W-1:0] ch, input logic [BYTE_W-1:0] nxt,
                 input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {nxt, ch};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    phase_bytes++;
  endtask

  task write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait until every owed cell has come out
  task settle(input int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // random string content; long strings without newlines run into the right edge
  task gen_string(input int nchars, input bit with_newlines);
    int kind;
    logic [BYTE_W-1:0] b;
    str_bytes.delete();
    repeat (nchars) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        str_bytes.push_back(BYTE_W'($urandom_range(8'h7E, 8'h20)));
      end else if (kind < 42) begin
        str_bytes.push_back(BYTE_W'($urandom_range(8'hDF, 8'hA1)));
      end else if (kind < 47) begin
        str_bytes.push_back(BYTE_W'($urandom_range(8'hFA, 8'hF0)));
      end else if (kind < 75) begin
        if ($urandom_range(1)) b = BYTE_W'($urandom_range(8'h9F, 8'h81));
        else b = BYTE_W'($urandom_range(8'hEF, 8'hE0));
        str_bytes.push_back(b);
        b = BYTE_W'($urandom_range(8'hFC, 8'h40));
        if (b == 8'h7F) b = 8'h80;
        str_bytes.push_back(b);
      end else if (kind < 85 && with_newlines) begin
        str_bytes.push_back(NEWLINE_BYTE);
      end else begin
        str_bytes.push_back(BYTE_W'($urandom));
      end
    end
  endtask

  // send the built string; a few lookahead bytes are replaced by noise
  task play_string(input int noise_pct);
    logic [BYTE_W-1:0] nxt;
    for (int i = 0; i < str_bytes.size(); i++) begin
      nxt = (i + 1 < str_bytes.size()) ? str_bytes[i + 1] : 8'h00;
      if ($urandom_range(99) < noise_pct) nxt = BYTE_W'($urandom);
      send_byte(str_bytes[i], nxt, i == str_bytes.size() - 1);
    end
  endtask

  task run_phase(input logic [CFG_DATA_W-1:0] col_val, input logic [CFG_DATA_W-1:0] row_val,
                 input int s_idle, input int r_stall, input int hold, input int n_bytes);
    write_reg(REG_START_COLUMN, col_val);
    write_reg(REG_START_ROW, row_val);
    send_idle = s_idle;
    recv_stall = r_stall;
    hold_req = hold;
    phase_bytes = 0;
    while (phase_bytes < n_bytes) begin
      if ($urandom_range(5) == 0) gen_string($urandom_range(90, 45), 1'b0);
      else gen_string($urandom_range(20, 1), 1'b1);
      play_string($urandom_range(9) == 0 ? 30 : 3);
    end
    settle(SETTLE_CYCLES);
  endtask

  initial begin
    sb = new;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: half-width range ends, zero and unmapped bytes
    send_byte(8'h20, 8'h7E, 1'b0);
    send_byte(8'h7E, 8'hA1, 1'b0);
    send_byte(8'hA1, 8'hDF, 1'b0);
    send_byte(8'hDF, 8'hF0, 1'b0);
    send_byte(8'hF0, 8'hFA, 1'b0);
    send_byte(8'hFA, 8'h00, 1'b0);
    send_byte(8'h00, 8'hFF, 1'b0);
    send_byte(8'hFF, 8'h00, 1'b1);
    // directed: pairs at table ends, a lead with no font row, newline
    send_byte(8'h81, 8'h40, 1'b0);
    send_byte(8'h40, 8'hEE, 1'b0);
    send_byte(8'hEE, 8'hFC, 1'b0);
    send_byte(8'hFC, 8'h85, 1'b0);
    send_byte(8'h85, 8'h80, 1'b0);
    send_byte(8'h80, 8'h0A, 1'b0);
    send_byte(NEWLINE_BYTE, 8'h9F, 1'b0);
    send_byte(8'h9F, 8'h7E, 1'b0);
    send_byte(8'h7E, 8'h88, 1'b0);
    // lead dropped by a newline, trail taken whatever the lookahead said
    send_byte(8'h88, 8'h41, 1'b0);
    send_byte(NEWLINE_BYTE, 8'h89, 1'b0);
    send_byte(8'h89, 8'h50, 1'b0);
    send_byte(8'h30, 8'h81, 1'b0);
    // lead without a trail draws as half-width, lead on the last byte is lost
    send_byte(8'h81, 8'h20, 1'b0);
    send_byte(8'h20, 8'hE0, 1'b0);
    send_byte(8'hE0, 8'h40, 1'b1);
    settle(SETTLE_CYCLES);

    // register extremes, then the idling mixes and a receiver hold-off
    run_phase(16'd511, 16'hFFFF, 0, 0, 0, 60);
    run_phase(16'd474, 16'd65530, 53, 0, 0, 250);
    run_phase(16'd0, 16'd0, 0, 53, 0, 250);
    run_phase({7'($urandom), 9'($urandom_range(300))}, 16'($urandom), 19, 19, 0, 250);
    run_phase(16'($urandom_range(100)), 16'($urandom), 0, 0, HOLD_OFF_CYCLES, 200);
    run_phase(16'($urandom_range(468)), 16'd65500, 0, 0, 0, 270);
    settle(20);

    $display("covered %0d bytes in %0d strings, %0d cells checked, %0d double-width",
             sb.bytes_seen, sb.strings_seen, sb.cells_checked, sb.pairs_seen);
    $display("with %0d newlines, %0d right-edge stops and %0d row wraps, %0d errors",
             sb.newlines_seen, sb.edge_stops, sb.row_wraps, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/sjgl_pkg.sv
sv/sjgl_front.sv
sv/sjgl_queue.sv
sv/sjgl_back.sv
sv/shift_jis_glyph_layout.sv
bench/shift_jis_glyph_layout_tb.sv
